// ===== hdl/tdsu_pkg.sv =====
package tdsu_pkg;

  // Command codes
  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_DELAY   = 3'd1;
  localparam logic [2:0] FN_SUSPEND = 3'd2;
  localparam logic [2:0] FN_RESUME  = 3'd3;
  localparam logic [2:0] FN_ENABLE  = 3'd4;
  localparam logic [2:0] FN_DISABLE = 3'd5;

  localparam int unsigned MASK_W  = 8;
  localparam int unsigned TICKS_W = 16;
  localparam int unsigned TID_W   = 3;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned COUNT_W = 32;

  // Disable mask after reset: only thread 0 enabled
  localparam logic [MASK_W-1:0] DIS_RESET = 8'hfe;

  // Command travelling down the cell chain
  typedef struct packed {
    logic               vld;
    logic [FUNC_W-1:0]  func;
    logic [TID_W-1:0]   tid;
    logic [TICKS_W-1:0] ticks;
  } cmd_t;

endpackage

// ===== hdl/tdsu_cell.sv =====
module tdsu_cell #(
  parameter int CELL_ID    = 0,
  parameter int DELAY_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tdsu_pkg::cmd_t cmd_in,
  output tdsu_pkg::cmd_t cmd_out,
  output logic          dis,
  output logic          sus,
  output logic          dly
);

  logic                  dis_r, dis_nxt;
  logic                  sus_r, sus_nxt;
  logic                  dly_r, dly_nxt;
  logic [DELAY_BITS-1:0] cnt_r, cnt_nxt;
  logic [DELAY_BITS-1:0] cnt_dec;
  logic [31:0]           ticks_ext;
  tdsu_pkg::cmd_t        cmd_r;
  logic                  hit;

  assign ticks_ext = {16'b0, cmd_in.ticks};
  assign cnt_dec   = cnt_r - {{(DELAY_BITS-1){1'b0}}, 1'b1};
  assign hit       = (cmd_in.tid == tdsu_pkg::TID_W'(CELL_ID));

  always_comb begin
    dis_nxt = dis_r;
    sus_nxt = sus_r;
    dly_nxt = dly_r;
    cnt_nxt = cnt_r;
    if (cmd_in.vld) begin
      if (cmd_in.func == tdsu_pkg::FN_TICK) begin
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          dly_nxt = 1'b0;
        end
      end else if (hit) begin
        case (cmd_in.func)
          tdsu_pkg::FN_DELAY: begin
            cnt_nxt = ticks_ext[DELAY_BITS-1:0];
            dly_nxt = 1'b1;
          end
          tdsu_pkg::FN_SUSPEND: sus_nxt = 1'b1;
          tdsu_pkg::FN_RESUME:  sus_nxt = 1'b0;
          tdsu_pkg::FN_ENABLE:  dis_nxt = 1'b0;
          tdsu_pkg::FN_DISABLE: dis_nxt = 1'b1;
          default: ;
        endcase
      end
    end
  end

  // payload moves on to the neighbor every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dis_r <= tdsu_pkg::DIS_RESET[CELL_ID];
      sus_r <= 1'b0;
      dly_r <= 1'b0;
      cnt_r <= '0;
      cmd_r <= '0;
    end else begin
      dis_r <= dis_nxt;
      sus_r <= sus_nxt;
      dly_r <= dly_nxt;
      cnt_r <= cnt_nxt;
      cmd_r <= cmd_in;
    end
  end

  assign cmd_out = cmd_r;
  assign dis     = dis_r;
  assign sus     = sus_r;
  assign dly     = dly_r;

endmodule

// ===== hdl/thread_delay_status_unit_core.sv =====
// Channel  | Direction | Ports
// ---------+-----------+-------------------------------------------------------
// in       | input     | in_valid, in_ready, in_func, in_thread_id, in_delay_ticks
// out      | output    | out_valid, out_ready, out_disabled_mask,
//          |           | out_suspended_mask, out_delayed_mask, out_tick_count
//
// A command enters a head register and walks the chain of THREADS cells, one
// cell per cycle; each cell holds one thread's mask bits and delay counter.
// The result is registered once the command leaves the last cell; the next
// transaction is taken once the chain is empty and the spare result slot is free.
// A finished result sits in the output register (plus one spare slot) while
// out_ready is low. Synchronous active-low reset: thread 0 enabled, other
// thread, tick and control state cleared; result data registers not reset.
module thread_delay_status_unit_core #(
  parameter int THREADS    = 8,
  parameter int DELAY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [2:0]  in_thread_id,
  input  logic [15:0] in_delay_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_disabled_mask,
  output logic [7:0]  out_suspended_mask,
  output logic [7:0]  out_delayed_mask,
  output logic [31:0] out_tick_count
);

  localparam int MW = tdsu_pkg::MASK_W;

  tdsu_pkg::cmd_t chain [THREADS+1];
  logic [THREADS-1:0] dis_v, sus_v, dly_v;
  logic [MW-1:0]      dis_m, sus_m, dly_m;

  logic        busy_r, busy_nxt;
  logic        ov_r, ov_nxt;
  logic        pv_r, pv_nxt;
  logic [31:0] tick_r;
  tdsu_pkg::cmd_t head_r;

  logic [MW-1:0] o_dis_r, o_sus_r, o_dly_r, p_dis_r, p_sus_r, p_dly_r;
  logic [31:0]   o_tick_r, p_tick_r;

  logic in_fire, out_fire, done, load_out, load_spare, spare_to_out;

  assign in_ready = !busy_r && !pv_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = ov_r && out_ready;
  assign done     = chain[THREADS].vld;

  // chain head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r.vld <= in_fire;
      if (in_fire) begin
        head_r.func  <= in_func;
        head_r.tid   <= in_thread_id;
        head_r.ticks <= in_delay_ticks;
      end
    end
  end

  assign chain[0] = head_r;

  for (genvar t = 0; t < THREADS; t++) begin : g_cell
    tdsu_cell #(
      .CELL_ID    (t),
      .DELAY_BITS (DELAY_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd_in  (chain[t]),
      .cmd_out (chain[t+1]),
      .dis     (dis_v[t]),
      .sus     (sus_v[t]),
      .dly     (dly_v[t])
    );
  end

  // mask bits from THREADS upward read zero
  for (genvar b = 0; b < MW; b++) begin : g_mask
    if (b < THREADS) begin : g_live
      assign dis_m[b] = dis_v[b];
      assign sus_m[b] = sus_v[b];
      assign dly_m[b] = dly_v[b];
    end else begin : g_zero
      assign dis_m[b] = 1'b0;
      assign sus_m[b] = 1'b0;
      assign dly_m[b] = 1'b0;
    end
  end

  // tick counter updates at acceptance; only one command is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (in_fire && in_func == tdsu_pkg::FN_TICK) begin
      tick_r <= tick_r + 32'd1;
    end
  end

  // result slots: output register plus one spare
  always_comb begin
    load_out     = 1'b0;
    load_spare   = 1'b0;
    spare_to_out = 1'b0;
    ov_nxt       = ov_r;
    pv_nxt       = pv_r;
    busy_nxt     = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end
    if (out_fire) begin
      ov_nxt = 1'b0;
    end
    if (pv_r && (!ov_r || out_fire)) begin
      spare_to_out = 1'b1;
      ov_nxt       = 1'b1;
      pv_nxt       = 1'b0;
    end
    if (done) begin
      busy_nxt = 1'b0;
      if (!ov_nxt) begin
        load_out = 1'b1;
        ov_nxt   = 1'b1;
      end else begin
        load_spare = 1'b1;
        pv_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      pv_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      pv_r   <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_dis_r  <= dis_m;
      o_sus_r  <= sus_m;
      o_dly_r  <= dly_m;
      o_tick_r <= tick_r;
    end else if (spare_to_out) begin
      o_dis_r  <= p_dis_r;
      o_sus_r  <= p_sus_r;
      o_dly_r  <= p_dly_r;
      o_tick_r <= p_tick_r;
    end
    if (load_spare) begin
      p_dis_r  <= dis_m;
      p_sus_r  <= sus_m;
      p_dly_r  <= dly_m;
      p_tick_r <= tick_r;
    end
  end

  assign out_valid          = ov_r;
  assign out_disabled_mask  = o_dis_r;
  assign out_suspended_mask = o_sus_r;
  assign out_delayed_mask   = o_dly_r;
  assign out_tick_count     = o_tick_r;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for thread_delay_status_unit_core.
module tb_top;

  // Codes with no defined command; the block must leave its state alone.
  localparam logic [2:0] FN_NOP_6 = 3'd6;
  localparam logic [2:0] FN_NOP_7 = 3'd7;

  localparam int unsigned TB_THREADS  = 8;
  localparam int unsigned CHAIN_LAT   = TB_THREADS + 1;
  localparam int unsigned RANDOM_CMDS = 600;

  // One entry of the command backlog. A hold entry carries no command: the
  // driver stops sending until every outstanding result has come back.
  typedef struct {
    bit                           hold;
    logic [tdsu_pkg::FUNC_W-1:0]  func;
    logic [tdsu_pkg::TID_W-1:0]   tid;
    logic [tdsu_pkg::TICKS_W-1:0] ticks;
  } thread_cmd_t;

  typedef struct packed {
    logic [tdsu_pkg::MASK_W-1:0]  disabled;
    logic [tdsu_pkg::MASK_W-1:0]  suspended;
    logic [tdsu_pkg::MASK_W-1:0]  delayed;
    logic [tdsu_pkg::COUNT_W-1:0] tick_count;
  } thread_status_t;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_ready;
  logic [2:0]         in_func            = '0;
  logic [2:0]         in_thread_id       = '0;
  logic [15:0]        in_delay_ticks     = '0;
  logic               out_valid;
  logic               out_ready          = 1'b0;
  logic [7:0]         out_disabled_mask;
  logic [7:0]         out_suspended_mask;
  logic [7:0]         out_delayed_mask;
  logic [31:0]        out_tick_count;

  thread_delay_status_unit_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_thread_id       (in_thread_id),
    .in_delay_ticks     (in_delay_ticks),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_disabled_mask  (out_disabled_mask),
    .out_suspended_mask (out_suspended_mask),
    .out_delayed_mask   (out_delayed_mask),
    .out_tick_count     (out_tick_count)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow copy of the thread state, starting from the post-reset values.
  // ---------------------------------------------------------------------
  logic [tdsu_pkg::MASK_W-1:0]  shadow_disabled  = tdsu_pkg::DIS_RESET;
  logic [tdsu_pkg::MASK_W-1:0]  shadow_suspended = '0;
  logic [tdsu_pkg::MASK_W-1:0]  shadow_delayed   = '0;
  logic [tdsu_pkg::TICKS_W-1:0] shadow_counter [TB_THREADS] = '{default: '0};
  logic [tdsu_pkg::COUNT_W-1:0] shadow_ticks     = '0;

  thread_cmd_t    cmd_backlog [$];
  thread_status_t status_expected [$];
  int unsigned    mismatches = 0;

  // Applies one command to the shadow state and returns the status it
  // leaves behind. A tick counts down every thread's counter, delayed or
  // not; a counter landing on zero drops its delay bit.
  function automatic thread_status_t apply_command(input logic [2:0] f,
                                                   input logic [2:0] tid,
                                                   input logic [15:0] dticks);
    thread_status_t s;
    if (f == tdsu_pkg::FN_TICK) begin
      shadow_ticks = shadow_ticks + 1'b1;
      for (int t = 0; t < TB_THREADS; t++) begin
        shadow_counter[t] = shadow_counter[t] - 1'b1;
        if (shadow_counter[t] == '0) shadow_delayed[t] = 1'b0;
      end
    end else begin
      case (f)
        tdsu_pkg::FN_DELAY: begin
          shadow_counter[tid] = dticks;
          shadow_delayed[tid] = 1'b1;
        end
        tdsu_pkg::FN_SUSPEND: shadow_suspended[tid] = 1'b1;
        tdsu_pkg::FN_RESUME:  shadow_suspended[tid] = 1'b0;
        tdsu_pkg::FN_ENABLE:  shadow_disabled[tid]  = 1'b0;
        tdsu_pkg::FN_DISABLE: shadow_disabled[tid]  = 1'b1;
        default: ;
      endcase
    end
    s = {shadow_disabled, shadow_suspended, shadow_delayed, shadow_ticks};
    return s;
  endfunction

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Delay values: short ones so delays expire inside a sequence, plus the
  // full range and both ends of it.
  function automatic logic [15:0] pick_ticks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 10));
    if (r < 90) return 16'($urandom_range(0, 16'hffff));
    if (r < 95) return 16'h0000;
    return 16'hffff;
  endfunction

  task automatic push_cmd(input logic [2:0] f, input logic [2:0] tid,
                          input logic [15:0] dticks);
    thread_cmd_t c;
    c.hold  = 1'b0;
    c.func  = f;
    c.tid   = tid;
    c.ticks = dticks;
    cmd_backlog.push_back(c);
  endtask

  task automatic push_hold();
    thread_cmd_t c;
    c.hold  = 1'b1;
    c.func  = tdsu_pkg::FN_TICK;
    c.tid   = '0;
    c.ticks = '0;
    cmd_backlog.push_back(c);
  endtask

  // ---------------------------------------------------------------------
  // Driver: one command per transaction, with random gaps in between.
  // The shadow state advances at the edge where the command is accepted.
  // ---------------------------------------------------------------------
  int unsigned send_gap     = 0;
  int unsigned steady_sends = 0;
  bit          draining     = 1'b0;

  always @(posedge clk) begin
    thread_cmd_t c;
    logic        next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        status_expected.push_back(apply_command(in_func, in_thread_id, in_delay_ticks));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (draining) begin
          // Hold off until the block has handed back everything in flight.
          if (status_expected.size() == 0) draining = 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0) begin
          c = cmd_backlog.pop_front();
          if (c.hold) begin
            draining = 1'b1;
          end else begin
            in_func        <= c.func;
            in_thread_id   <= c.tid;
            in_delay_ticks <= c.ticks;
            next_valid     = 1'b1;
            if (steady_sends > 0) begin
              steady_sends--;
              send_gap = 0;
            end else begin
              send_gap = pick_gap();
              if ($urandom_range(0, 29) == 0) steady_sends = $urandom_range(20, 60);
            end
          end
        end
      end
      // Single update per edge so a held valid is never dropped and re-raised.
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result transaction is checked against the oldest
  // prediction, field by field. Back-pressure comes from random stalls.
  // ---------------------------------------------------------------------
  int unsigned ready_stall = 0;
  int unsigned steady_recv = 0;

  always @(posedge clk) begin
    thread_status_t got;
    thread_status_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_disabled_mask, out_suspended_mask, out_delayed_mask,
               out_tick_count};
        if (status_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: dis=%h sus=%h dly=%h ticks=%h",
                     got.disabled, got.suspended, got.delayed, got.tick_count);
        end else begin
          want = status_expected.pop_front();
          if (got.disabled !== want.disabled || got.suspended !== want.suspended ||
              got.delayed !== want.delayed || got.tick_count !== want.tick_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result differs: exp dis=%h sus=%h dly=%h ticks=%h, ",
                        "got dis=%h sus=%h dly=%h ticks=%h"},
                       want.disabled, want.suspended, want.delayed, want.tick_count,
                       got.disabled, got.suspended, got.delayed, got.tick_count);
          end
        end
      end
      if (ready_stall > 0) begin
        ready_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (steady_recv > 0) begin
          steady_recv--;
        end else if ($urandom_range(0, 3) == 0) begin
          ready_stall = pick_gap();
          if ($urandom_range(0, 19) == 0) steady_recv = $urandom_range(30, 120);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned issued;
    int unsigned r;
    int unsigned span;
    logic [2:0]  tid;

    // Directed: reset state seen through the unused codes, zero and
    // maximum delays, expiry after one and two ticks, every mask command
    // at both ends of the thread range, alternating bit patterns.
    push_cmd(FN_NOP_6,             3'd7, 16'hffff);
    push_cmd(FN_NOP_7,             3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_TICK,    3'd5, 16'h1234);
    push_cmd(tdsu_pkg::FN_DELAY,   3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_TICK,    3'd0, 16'h0000);  // zero delay wraps, thread stays delayed
    push_cmd(tdsu_pkg::FN_DELAY,   3'd7, 16'hffff);
    push_cmd(tdsu_pkg::FN_DELAY,   3'd3, 16'h0001);
    push_cmd(tdsu_pkg::FN_TICK,    3'd2, 16'h0000);  // thread 3 expires
    push_cmd(tdsu_pkg::FN_DELAY,   3'd5, 16'h0002);
    push_cmd(tdsu_pkg::FN_TICK,    3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_TICK,    3'd0, 16'h0000);  // thread 5 expires
    push_cmd(tdsu_pkg::FN_SUSPEND, 3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_SUSPEND, 3'd7, 16'h0000);
    push_cmd(tdsu_pkg::FN_SUSPEND, 3'd7, 16'h0000);
    push_cmd(tdsu_pkg::FN_RESUME,  3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_RESUME,  3'd7, 16'h0000);
    push_cmd(tdsu_pkg::FN_ENABLE,  3'd7, 16'h0000);
    push_cmd(tdsu_pkg::FN_ENABLE,  3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_DISABLE, 3'd0, 16'h0000);
    push_cmd(tdsu_pkg::FN_DISABLE, 3'd7, 16'h0000);
    push_cmd(tdsu_pkg::FN_ENABLE,  3'd4, 16'h0000);
    push_cmd(tdsu_pkg::FN_DELAY,   3'd2, 16'haaaa);
    push_cmd(tdsu_pkg::FN_DELAY,   3'd6, 16'h5555);
    push_hold();
    push_cmd(tdsu_pkg::FN_TICK,    3'd1, 16'hffff);

    // Random: mostly delay-then-tick sequences so delays actually expire,
    // mixed with single commands and the odd unused code.
    issued = 0;
    while (issued < RANDOM_CMDS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        tid  = 3'($urandom_range(0, 7));
        span = $urandom_range(1, 6);
        push_cmd(tdsu_pkg::FN_DELAY, tid, 16'(span));
        issued++;
        repeat (span + $urandom_range(0, 2)) begin
          if ($urandom_range(0, 4) == 0)
            push_cmd(3'($urandom_range(tdsu_pkg::FN_SUSPEND, tdsu_pkg::FN_DISABLE)),
                     3'($urandom_range(0, 7)), pick_ticks());
          else
            push_cmd(tdsu_pkg::FN_TICK, 3'($urandom_range(0, 7)), pick_ticks());
          issued++;
        end
      end else if (r < 95) begin
        push_cmd(3'($urandom_range(tdsu_pkg::FN_TICK, tdsu_pkg::FN_DISABLE)),
                 3'($urandom_range(0, 7)), pick_ticks());
        issued++;
      end else begin
        push_cmd($urandom_range(0, 1) ? FN_NOP_6 : FN_NOP_7, 3'($urandom_range(0, 7)),
                 pick_ticks());
        issued++;
      end
      if ($urandom_range(0, 39) == 0) push_hold();
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || in_valid || draining || status_expected.size() > 0)
      @(posedge clk);
    // Let a stray extra result surface before judging.
    repeat (4 * CHAIN_LAT) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
